// ----- hw/rtl/rau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned DefWidth = 64;

    // operation codes
    localparam logic [2:0] OpAdd = 3'd0;
    localparam logic [2:0] OpSub = 3'd1;
    localparam logic [2:0] OpMul = 3'd2;
    localparam logic [2:0] OpDiv = 3'd3;
    localparam logic [2:0] OpCmp = 3'd4;
    localparam logic [2:0] OpNrm = 3'd5;

    // status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StZero = 2'd1;
    localparam logic [1:0] StOvf  = 2'd2;

    // datapath commands
    typedef struct packed {
        logic load;      // capture operands, decode
        logic mul;       // run one multiply step
        logic combine;   // form numerator and denominator
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;    // register the result
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic bad;       // error before arithmetic
        logic is_cmp;
        logic mul_done;
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage : rau_pkg
`default_nettype wire

// ----- hw/rtl/rau_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit: steps the datapath through
// multiply, gcd and division phases.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import rau_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.bad) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_sts.mul_done) begin
                    if (i_sts.is_cmp) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.combine = 1'b1;
                        n_state       = S_GCD;
                    end
                end
            end
            S_GCD: begin
                // combine registers the operands; the first gcd step loads them
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule : rau_ctrl
`default_nettype wire

// ----- hw/rtl/rau_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand decode, 32x32 multiply-accumulate for the cross products,
// binary gcd and restoring long division of numerator and denominator.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rau_pkg::t_cmd i_cmd,
    input  wire logic [2:0]    i_operation,
    input  wire logic [63:0]   i_a_num,
    input  wire logic [63:0]   i_a_den,
    input  wire logic [63:0]   i_b_num,
    input  wire logic [63:0]   i_b_den,
    output rau_pkg::t_sts      o_sts,
    output logic [63:0]        o_res_num,
    output logic [62:0]        o_res_den,
    output logic [1:0]         o_status,
    output logic               o_less_than,
    output logic               o_equal
);
    import rau_pkg::*;

    localparam int unsigned W2 = 2 * WIDTH;
    localparam int unsigned CW = $clog2(W2 + 1);

    // decoded magnitudes and signs
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic             r_aneg, r_bneg, r_aok, r_bok;
    logic [2:0]       r_op;

    function automatic logic [WIDTH-1:0] f_mag(input logic [63:0] v);
        logic [WIDTH-1:0] t;
        t = v[WIDTH-1:0];
        return t[WIDTH-1] ? (~t + 1'b1) : t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_an   <= f_mag(i_a_num);
            r_ad   <= f_mag(i_a_den);
            r_bn   <= f_mag(i_b_num);
            r_bd   <= f_mag(i_b_den);
            r_aneg <= (i_a_num[WIDTH-1] != i_a_den[WIDTH-1]) && (i_a_num[WIDTH-1:0] != '0);
            r_bneg <= (i_b_num[WIDTH-1] != i_b_den[WIDTH-1]) && (i_b_num[WIDTH-1:0] != '0);
            r_aok  <= (i_a_den[WIDTH-1:0] != '0);
            r_bok  <= (i_b_den[WIDTH-1:0] != '0);
        end
    end

    logic bad;
    assign bad = (r_op > OpNrm) || !r_aok || ((r_op != OpNrm) && !r_bok) ||
                 ((r_op == OpDiv) && (r_bn == '0));

    // ---------------- multiply: 3 products, 4 partial products each ----------
    // sequence index: product p (0..2), partial k (0..3)
    localparam int unsigned HW = (WIDTH + 1) / 2;
    logic [3:0]        r_mseq;
    logic [W2-1:0]     r_p0, r_p1, r_p2;
    logic [WIDTH-1:0]  mx, my;
    logic [HW-1:0]     hx, hy;
    logic [2*HW-1:0]   pp;
    logic [W2-1:0]     pp_sh;
    logic [1:0]        mp, mk;

    assign mp = r_mseq[3:2];
    assign mk = r_mseq[1:0];

    // operand pairs per product
    always_comb begin
        mx = r_an; my = r_bd;
        unique case (mp)
            2'd0: begin
                mx = r_an;
                my = (r_op == OpMul) ? r_bn : r_bd;
            end
            2'd1: begin
                mx = (r_op == OpMul || r_op == OpDiv) ? r_ad : r_bn;
                my = (r_op == OpMul) ? r_bd : (r_op == OpDiv) ? r_bn : r_ad;
            end
            default: begin
                mx = r_ad;
                my = r_bd;
            end
        endcase
        hx = mk[0] ? HW'(mx >> HW) : mx[HW-1:0];
        hy = mk[1] ? HW'(my >> HW) : my[HW-1:0];
    end

    assign pp    = hx * hy;
    assign pp_sh = W2'(pp) << (HW * (32'(mk[0]) + 32'(mk[1])));

    logic [W2-1:0] r_pp_sh;
    logic          r_pp_v;
    logic [1:0]    r_pp_p;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mseq <= '0;
            r_p0   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
            r_pp_v <= 1'b0;
        end else if (i_cmd.mul) begin
            r_pp_sh <= pp_sh;
            r_pp_p  <= mp;
            r_pp_v  <= (r_mseq != 4'd12);
            if (r_mseq != 4'd12) begin
                r_mseq <= r_mseq + 4'd1;
            end
            if (r_pp_v) begin
                unique case (r_pp_p)
                    2'd0:    r_p0 <= r_p0 + r_pp_sh;
                    2'd1:    r_p1 <= r_p1 + r_pp_sh;
                    default: r_p2 <= r_p2 + r_pp_sh;
                endcase
            end
        end
    end

    logic mul_done;
    assign mul_done = (r_mseq == 4'd12) && !r_pp_v;

    // ---------------- combine ----------------
    logic          n_neg;
    logic [W2-1:0] n_num, n_den;
    logic          sub_neg;
    logic          cmp_ge;

    assign sub_neg = (r_op == OpSub) ? (!r_bneg && r_bn != '0) : r_bneg;
    assign cmp_ge  = (r_p0 >= r_p1);

    always_comb begin
        n_neg = r_aneg != r_bneg;
        n_num = r_p0;
        n_den = r_p1;
        unique case (r_op)
            OpAdd, OpSub: begin
                n_den = r_p2;
                if (r_aneg == sub_neg) begin
                    n_num = r_p0 + r_p1;
                    n_neg = r_aneg;
                end else if (cmp_ge) begin
                    n_num = r_p0 - r_p1;
                    n_neg = r_aneg;
                end else begin
                    n_num = r_p1 - r_p0;
                    n_neg = sub_neg;
                end
            end
            OpNrm: begin
                n_num = W2'(r_an);
                n_den = W2'(r_ad);
                n_neg = r_aneg;
            end
            default: begin
                n_num = r_p0;
                n_den = r_p1;
            end
        endcase
    end

    // ---------------- binary gcd ----------------
    logic [W2-1:0] r_num, r_den, r_gx, r_gy;
    logic          r_neg;
    logic [CW-1:0] r_gk;
    logic [1:0]    r_gph;   // 0 init, 1 common twos, 2 x even, 3 main
    logic          r_gdone;

    always_ff @(posedge i_clk) begin
        if (i_cmd.combine) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_neg   <= n_neg;
            r_gph   <= 2'd0;
            r_gdone <= 1'b0;
        end else if (i_cmd.gcd_step && !r_gdone) begin
            unique case (r_gph)
                2'd0: begin
                    r_gk <= '0;
                    r_gy <= r_den;
                    if (r_num == '0) begin
                        r_gx    <= r_den;
                        r_gdone <= 1'b1;
                    end else begin
                        r_gx <= r_num;
                        if (r_den == '0) begin
                            r_gdone <= 1'b1;
                        end else begin
                            r_gph <= 2'd1;
                        end
                    end
                end
                2'd1: begin
                    if (!r_gx[0] && !r_gy[0]) begin
                        r_gx <= r_gx >> 1;
                        r_gy <= r_gy >> 1;
                        r_gk <= r_gk + 1'b1;
                    end else begin
                        r_gph <= 2'd2;
                    end
                end
                2'd2: begin
                    if (!r_gx[0]) begin
                        r_gx <= r_gx >> 1;
                    end else begin
                        r_gph <= 2'd3;
                    end
                end
                default: begin
                    if (r_gy == '0) begin
                        r_gx    <= r_gx << r_gk;
                        r_gdone <= 1'b1;
                    end else if (!r_gy[0]) begin
                        r_gy <= r_gy >> 1;
                    end else if (r_gx > r_gy) begin
                        r_gx <= r_gy;
                        r_gy <= r_gx - r_gy;
                    end else begin
                        r_gy <= r_gy - r_gx;
                    end
                end
            endcase
        end
    end

    // ---------------- long division, numerator and denominator together ------
    logic [W2-1:0] r_qn, r_qd, r_rn, r_rd, r_sn, r_sd;
    logic [CW-1:0] r_dcnt;
    logic [W2:0]   tn, td;

    assign tn = {r_rn, r_sn[W2-1]};
    assign td = {r_rd, r_sd[W2-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dcnt <= CW'(W2);
            r_sn   <= r_num;
            r_sd   <= r_den;
            r_rn   <= '0;
            r_rd   <= '0;
            r_qn   <= '0;
            r_qd   <= '0;
        end else if (i_cmd.div_step && r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
            r_sn   <= r_sn << 1;
            r_sd   <= r_sd << 1;
            if (tn >= {1'b0, r_gx}) begin
                r_rn <= W2'(tn - {1'b0, r_gx});
                r_qn <= {r_qn[W2-2:0], 1'b1};
            end else begin
                r_rn <= tn[W2-1:0];
                r_qn <= {r_qn[W2-2:0], 1'b0};
            end
            if (td >= {1'b0, r_gx}) begin
                r_rd <= W2'(td - {1'b0, r_gx});
                r_qd <= {r_qd[W2-2:0], 1'b1};
            end else begin
                r_rd <= td[W2-1:0];
                r_qd <= {r_qd[W2-2:0], 1'b0};
            end
        end
    end

    // ---------------- result ----------------
    logic [W2-1:0]    lim;
    logic             fneg, ovf, c_lt, c_eq;
    logic [WIDTH-1:0] rn_w;
    logic [63:0]      n_res_num;
    logic [62:0]      n_res_den;
    logic [1:0]       n_status;
    logic             n_less_than, n_equal;

    assign lim  = W2'(1) << (WIDTH - 1);
    assign fneg = r_neg && (r_qn != '0);
    assign ovf  = (r_qd >= lim) || (r_qn > lim) || ((r_qn == lim) && !fneg);
    assign rn_w = fneg ? (~r_qn[WIDTH-1:0] + 1'b1) : r_qn[WIDTH-1:0];
    assign c_eq = (r_aneg == r_bneg) && (r_p0 == r_p1);
    assign c_lt = (r_aneg != r_bneg) ? r_aneg :
                  (r_aneg ? (r_p0 > r_p1) : (r_p0 < r_p1));

    // result fields by outcome
    always_comb begin
        n_res_num   = '0;
        n_res_den   = '0;
        n_status    = StOk;
        n_less_than = 1'b0;
        n_equal     = 1'b0;
        if (bad) begin
            n_status = StZero;
        end else if (r_op == OpCmp) begin
            n_less_than = c_lt;
            n_equal     = c_eq;
        end else if (ovf) begin
            n_status = StOvf;
        end else begin
            n_res_num = 64'($signed(rn_w));
            n_res_den = 63'(r_qd[WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_res_num   <= n_res_num;
            o_res_den   <= n_res_den;
            o_status    <= n_status;
            o_less_than <= n_less_than;
            o_equal     <= n_equal;
        end
    end

    assign o_sts.bad      = bad;
    assign o_sts.is_cmp   = (r_op == OpCmp);
    assign o_sts.mul_done = mul_done;
    assign o_sts.gcd_done = r_gdone && !i_cmd.combine && i_rst_n;
    assign o_sts.div_done = (r_dcnt == '0);

endmodule : rau_dp
`default_nettype wire

// ----- hw/rtl/rational_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div/compare/normalize on signed fractions, gcd reduced.
// ----------------------------------------------------------------------------
// One transaction at a time: raise start while busy is low. The result
// appears with o_valid high for one cycle and cannot be held off. Error
// cases go from decode straight to finish and output; compare runs decode,
// the shared 32x32 multiplier for the three cross products, then finish
// and output. Other operations add the binary gcd on 2*WIDTH-bit values
// and a long division of numerator and denominator by the gcd before
// finish. busy drops the cycle after the strobe, so the next transaction
// can be accepted there.
module rational_arithmetic_unit #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [63:0] i_a_num,
    input  wire logic [63:0] i_a_den,
    input  wire logic [63:0] i_b_num,
    input  wire logic [63:0] i_b_den,
    output logic             o_valid,
    output logic [63:0]      o_res_num,
    output logic [62:0]      o_res_den,
    output logic [1:0]       o_status,
    output logic             o_less_than,
    output logic             o_equal
);
    import rau_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    rau_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_sts       (sts),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_status    (o_status),
        .o_less_than (o_less_than),
        .o_equal     (o_equal)
    );

    // a result strobe never coincides with an accepted start
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("strobe while idle");

    // overflow and error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != StOk) |-> (o_res_num == '0 && o_res_den == '0))
        else $error("nonzero result on error");

    // compare flags are exclusive
    a_cmp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_less_than && o_equal)) else $error("lt and eq both set");

endmodule : rational_arithmetic_unit
`default_nettype wire
